[rtl/spvf_pkg.sv]
// Package for the SPIR-V word stream filter.
// Holds the result kinds, instruction actions, protocol constants and the result set type.
// No dependencies.
package spvf_pkg;

	localparam int unsigned WORD_W = 32;

	// Header framing.
	localparam int unsigned HDR_IDX_W = 3;
	localparam logic [HDR_IDX_W-1:0] HEADER_WORDS = 3'd5;
	localparam int unsigned HDR_STORE_N = 4;
	localparam int unsigned HDR_STORE_IDX_W = 2;

	// Protocol constants.
	localparam logic [WORD_W-1:0] SPV_MAGIC = 32'h0723_0203;
	localparam logic [15:0] OPC_NAME = 16'd5;
	localparam logic [15:0] OPC_DECORATE = 16'd71;
	localparam logic [WORD_W-1:0] DEC_LINKAGE = 32'd41;

	// Configuration registers.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VERSION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VERSION = 1'd1;
	localparam logic [WORD_W-1:0] MIN_VERSION_RST = 32'h0001_0000;
	localparam logic [WORD_W-1:0] MAX_VERSION_RST = 32'h0001_0200;

	// Results caused by one input word.
	localparam int unsigned RES_MAX = 6;
	localparam int unsigned RES_CNT_W = 3;
	localparam int unsigned RES_IDX_W = 3;
	localparam int unsigned KIND_W = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA     = 3'd0,
		KIND_DONE     = 3'd1,
		KIND_MAGIC    = 3'd2,
		KIND_VERSION  = 3'd3,
		KIND_RESERVED = 3'd4,
		KIND_ZERO     = 3'd5,
		KIND_TRUNC    = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ACT_PASS = 2'd0,
		ACT_DROP = 2'd1,
		ACT_HOLD = 2'd2
	} act_t;

	// One set of results produced by a single input word.
	typedef struct packed {
		logic [RES_CNT_W-1:0] cnt;
		logic [RES_MAX-1:0][WORD_W-1:0] word;
		logic [RES_MAX-1:0][KIND_W-1:0] kind;
	} res_set_t;

	// Result buffer status seen by the input side.
	typedef struct packed {
		logic busy;
		logic last_take;
	} ob_stat_t;

endpackage

[rtl/spvf_parse.sv]
// Header check and instruction framing state for the SPIR-V word stream filter.
// Turns one registered word into a result set and updates the parse state.
// Depends on spvf_pkg.
module spvf_parse (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [spvf_pkg::WORD_W-1:0]   word,
	input  logic                          eos,
	input  logic [spvf_pkg::WORD_W-1:0]   min_version,
	input  logic [spvf_pkg::WORD_W-1:0]   max_version,
	output spvf_pkg::res_set_t            res
);

	logic [spvf_pkg::HDR_IDX_W-1:0] hidx_q, hidx_d;
	logic [spvf_pkg::WORD_W-1:0]    hstore_q [spvf_pkg::HDR_STORE_N];
	logic [15:0]                    wleft_q, wleft_d;
	logic [1:0]                     pos_q, pos_d;
	spvf_pkg::act_t                 act_q, act_d;
	logic [spvf_pkg::WORD_W-1:0]    held0_q, held1_q;
	logic                           failed_q, failed_d;

	logic                           hst_we, h0_we, h1_we;
	logic                           err, tail;
	spvf_pkg::kind_t                ekind, tkind;
	logic [spvf_pkg::RES_CNT_W-1:0] nd;
	logic [spvf_pkg::RES_MAX-1:0][spvf_pkg::WORD_W-1:0] dw;
	logic [15:0]                    wc;
	logic [15:0]                    op;

	assign wc = word[31:16];
	assign op = word[15:0];

	always_comb begin
		nd = '0;
		dw = '0;
		err = 1'b0;
		ekind = spvf_pkg::KIND_MAGIC;
		hidx_d = hidx_q;
		wleft_d = wleft_q;
		pos_d = pos_q;
		act_d = act_q;
		failed_d = failed_q;
		hst_we = 1'b0;
		h0_we = 1'b0;
		h1_we = 1'b0;
		if (!failed_q) begin
			if (hidx_q < spvf_pkg::HEADER_WORDS) begin
				priority if (hidx_q == 3'd0 && word != spvf_pkg::SPV_MAGIC) begin
					err = 1'b1;
					ekind = spvf_pkg::KIND_MAGIC;
				end else if (hidx_q == 3'd1 && (word < min_version || word > max_version)) begin
					err = 1'b1;
					ekind = spvf_pkg::KIND_VERSION;
				end else if (hidx_q >= spvf_pkg::HEADER_WORDS - 3'd1) begin
					if (word != '0) begin
						err = 1'b1;
						ekind = spvf_pkg::KIND_RESERVED;
					end else begin
						// Header passed: release the held words and the reserved word.
						dw[0] = hstore_q[0];
						dw[1] = hstore_q[1];
						dw[2] = hstore_q[2];
						dw[3] = hstore_q[3];
						dw[4] = word;
						nd = 3'd5;
						hidx_d = spvf_pkg::HEADER_WORDS;
					end
				end else begin
					hst_we = 1'b1;
					hidx_d = hidx_q + 3'd1;
				end
			end else if (wleft_q == '0) begin
				if (wc == '0) begin
					err = 1'b1;
					ekind = spvf_pkg::KIND_ZERO;
				end else begin
					wleft_d = wc - 16'd1;
					pos_d = 2'd1;
					priority if (op == spvf_pkg::OPC_NAME) begin
						act_d = spvf_pkg::ACT_DROP;
					end else if (op == spvf_pkg::OPC_DECORATE && wc >= 16'd3) begin
						act_d = spvf_pkg::ACT_HOLD;
						h0_we = 1'b1;
					end else begin
						act_d = spvf_pkg::ACT_PASS;
						dw[0] = word;
						nd = 3'd1;
					end
				end
			end else begin
				wleft_d = wleft_q - 16'd1;
				pos_d = (pos_q == 2'd3) ? 2'd3 : pos_q + 2'd1;
				unique case (act_q)
					spvf_pkg::ACT_PASS: begin
						dw[0] = word;
						nd = 3'd1;
					end
					spvf_pkg::ACT_HOLD: begin
						if (pos_q <= 2'd1) begin
							h1_we = 1'b1;
						end else if (word == spvf_pkg::DEC_LINKAGE) begin
							act_d = spvf_pkg::ACT_DROP;
						end else begin
							dw[0] = held0_q;
							dw[1] = held1_q;
							dw[2] = word;
							nd = 3'd3;
							act_d = spvf_pkg::ACT_PASS;
						end
					end
					default: begin
					end
				endcase
			end
			if (err) begin
				failed_d = 1'b1;
			end
		end

		// The error, done or truncated result always closes the set.
		tail = !failed_q && (err || eos);
		if (err) begin
			tkind = ekind;
		end else if (hidx_d < spvf_pkg::HEADER_WORDS || wleft_d != '0) begin
			tkind = spvf_pkg::KIND_TRUNC;
		end else begin
			tkind = spvf_pkg::KIND_DONE;
		end

		res.cnt = nd + {2'b00, tail};
		for (int i = 0; i < spvf_pkg::RES_MAX; i++) begin
			if (spvf_pkg::RES_CNT_W'(i) < nd) begin
				res.word[i] = dw[i];
				res.kind[i] = spvf_pkg::KIND_DATA;
			end else if (spvf_pkg::RES_CNT_W'(i) == nd && tail) begin
				res.word[i] = '0;
				res.kind[i] = tkind;
			end else begin
				res.word[i] = '0;
				res.kind[i] = spvf_pkg::KIND_DATA;
			end
		end

		// End of stream starts a fresh module.
		if (eos) begin
			hidx_d = '0;
			wleft_d = '0;
			pos_d = '0;
			act_d = spvf_pkg::ACT_PASS;
			failed_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidx_q <= '0;
			wleft_q <= '0;
			pos_q <= '0;
			act_q <= spvf_pkg::ACT_PASS;
			failed_q <= 1'b0;
		end else if (fire) begin
			hidx_q <= hidx_d;
			wleft_q <= wleft_d;
			pos_q <= pos_d;
			act_q <= act_d;
			failed_q <= failed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && hst_we) begin
			hstore_q[hidx_q[spvf_pkg::HDR_STORE_IDX_W-1:0]] <= word;
		end
		if (fire && h0_we) begin
			held0_q <= word;
		end
		if (fire && h1_we) begin
			held1_q <= word;
		end
	end

endmodule

[rtl/spvf_obuf.sv]
// Result buffer for the SPIR-V word stream filter.
// Holds one result set and hands it out one beat per cycle while out_stall is low.
// Depends on spvf_pkg.
module spvf_obuf (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  spvf_pkg::res_set_t           res,
	output spvf_pkg::ob_stat_t           stat,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [spvf_pkg::WORD_W-1:0]  out_word,
	output logic [spvf_pkg::KIND_W-1:0]  kind,
	output logic                         run_last
);

	logic [spvf_pkg::WORD_W-1:0]    word_q [spvf_pkg::RES_MAX];
	logic [spvf_pkg::KIND_W-1:0]    kind_q [spvf_pkg::RES_MAX];
	logic [spvf_pkg::RES_CNT_W-1:0] cnt_q;
	logic [spvf_pkg::RES_IDX_W-1:0] rd_q;
	logic                           busy_q;
	logic                           take;
	logic                           last;

	assign last = (rd_q == cnt_q - 3'd1);
	assign take = busy_q && !out_stall;

	assign stat.busy = busy_q;
	assign stat.last_take = take && last;

	assign out_valid = busy_q;
	assign out_word = word_q[rd_q];
	assign kind = kind_q[rd_q];
	assign run_last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			rd_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q <= res.cnt;
			rd_q <= '0;
		end else if (take) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				rd_q <= rd_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < spvf_pkg::RES_MAX; i++) begin
				word_q[i] <= res.word[i];
				kind_q[i] <= res.kind[i];
			end
		end
	end

endmodule

[rtl/spirv_word_stream_filter_unit.sv]
// Top level of the SPIR-V word stream filter.
// Instantiates spvf_parse and spvf_obuf; depends on spvf_pkg.
//
// Usage: a SPIR-V module enters one 32-bit word per beat on the in channel
// (in_word, end_of_stream, in_valid, in_stall). The five header words are checked
// and the first four held; all five leave together once the reserved word is zero.
// After the header, OpName instructions are removed, and OpDecorate with the
// LinkageAttributes decoration is removed once its third word is known. Every
// other word passes unchanged on the out channel (out_word, kind, run_last,
// out_valid, out_stall). kind carries data, done or an error code; run_last
// marks the last beat caused by one input word.
// Throughput: one word per cycle while each word gives at most one result and
// out_stall is low. A word that gives several results holds the single result
// buffer until its last beat is taken, so the end of the header (up to six beats)
// or a released OpDecorate (up to four beats) stalls the input once the next word
// waits in the input register. The input register keeps taking a word while
// results still wait to be taken. Reset clears the parse state and loads the
// default version bounds (1.0 to 1.2). While out_stall is high, the current beat
// holds and the input stalls once both the input register and the result buffer
// are occupied. The version bounds are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the block is idle (not enforced).
module spirv_word_stream_filter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [spvf_pkg::WORD_W-1:0]     in_word,
	input  logic                            end_of_stream,
	input  logic                            in_valid,
	output logic                            in_stall,
	output logic [spvf_pkg::WORD_W-1:0]     out_word,
	output logic [spvf_pkg::KIND_W-1:0]     kind,
	output logic                            run_last,
	output logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            cfg_we,
	input  logic [spvf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spvf_pkg::WORD_W-1:0]     cfg_wdata
);

	logic [spvf_pkg::WORD_W-1:0] min_version_q;
	logic [spvf_pkg::WORD_W-1:0] max_version_q;

	logic [spvf_pkg::WORD_W-1:0] word_s1;
	logic                        eos_s1;
	logic                        valid_s1;

	spvf_pkg::ob_stat_t          ob_stat;
	spvf_pkg::res_set_t          res;
	logic                        buf_free;
	logic                        adv;
	logic                        accept;

	// Version bound registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_version_q <= spvf_pkg::MIN_VERSION_RST;
			max_version_q <= spvf_pkg::MAX_VERSION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spvf_pkg::CFG_MIN_VERSION: min_version_q <= cfg_wdata;
				spvf_pkg::CFG_MAX_VERSION: max_version_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The registered word moves on when the result buffer is empty or hands out
	// its final beat in this cycle.
	assign buf_free = !ob_stat.busy || ob_stat.last_take;
	assign adv = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
			eos_s1 <= end_of_stream;
		end
	end

	spvf_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv),
		.word        (word_s1),
		.eos         (eos_s1),
		.min_version (min_version_q),
		.max_version (max_version_q),
		.res         (res)
	);

	// A word that causes no result never occupies the buffer.
	spvf_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && res.cnt != '0),
		.res       (res),
		.stat      (ob_stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.kind      (kind),
		.run_last  (run_last)
	);

	// Error, done and truncated results always end the beats of their word.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != spvf_pkg::KIND_DATA) |-> run_last)
		else $error("status result is not the last beat of its word");

	// Status results carry a zero word.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != spvf_pkg::KIND_DATA) |-> out_word == '0)
		else $error("status result carries a nonzero word");

	// The input only stalls while results are waiting to leave.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no pending result");

endmodule

[tb/spirv_word_stream_filter_unit_tb.sv]
// Self-checking bench for spirv_word_stream_filter_unit: a directed table and then random
// modules, with every output beat compared against a cycle-free model of the filter.
// Depends on spvf_pkg and the RTL of the unit; needs no other file.
module spirv_word_stream_filter_unit_tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned N_PHASES = 5;
	localparam int unsigned PRESSURE_PHASE = 2;
	localparam int unsigned DIR_ROWS = 26;

	// Random phases: version window, sender idle and receiver stall percentages, word budget.
	// The last window has its bounds crossed, so every version word is refused there.
	localparam logic [spvf_pkg::WORD_W-1:0] WIN_LO [N_PHASES] =
		'{32'h0001_0000, 32'h0000_0000, 32'h0001_0300, 32'h0001_0000, 32'hFFFF_FFFF};
	localparam logic [spvf_pkg::WORD_W-1:0] WIN_HI [N_PHASES] =
		'{32'h0001_0600, 32'hFFFF_FFFF, 32'h0001_0300, 32'h0001_0200, 32'h0000_0000};
	localparam int unsigned IDLE_PCT [N_PHASES] = '{0, 88, 0, 27, 27};
	localparam int unsigned STALL_PCT [N_PHASES] = '{0, 0, 88, 27, 27};
	localparam int unsigned PHASE_WORDS [N_PHASES] = '{35, 30, 35, 35, 20};

	// One input beat. When fixed is set, the single result of the beat is typed in the table.
	typedef struct packed {
		logic [spvf_pkg::WORD_W-1:0] word;
		logic                        eos;
		logic                        fixed;
		spvf_pkg::kind_t             fixed_kind;
	} beat_t;

	// One output beat that the filter owes.
	typedef struct packed {
		logic [spvf_pkg::WORD_W-1:0] word;
		spvf_pkg::kind_t             kind;
		logic                        last;
	} out_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [spvf_pkg::WORD_W-1:0] in_word = '0;
	logic end_of_stream = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [spvf_pkg::WORD_W-1:0] out_word;
	logic [spvf_pkg::KIND_W-1:0] kind;
	logic run_last;
	logic out_valid;
	logic out_stall = 1'b0;
	logic cfg_we = 1'b0;
	logic [spvf_pkg::CFG_IDX_W-1:0] cfg_index = spvf_pkg::CFG_MIN_VERSION;
	logic [spvf_pkg::WORD_W-1:0] cfg_wdata = '0;

	// Shadow of the payload: marks beats whose result is typed in the directed table.
	logic beat_fixed = 1'b0;
	spvf_pkg::kind_t beat_fixed_kind = spvf_pkg::KIND_DATA;

	// Filter state as the bench tracks it, plus its copy of the version bounds.
	logic [spvf_pkg::WORD_W-1:0] ver_lo = spvf_pkg::MIN_VERSION_RST;
	logic [spvf_pkg::WORD_W-1:0] ver_hi = spvf_pkg::MAX_VERSION_RST;
	logic [spvf_pkg::HDR_IDX_W-1:0] hdr_idx = '0;
	logic [spvf_pkg::WORD_W-1:0] hdr_words [spvf_pkg::HDR_STORE_N];
	logic [15:0] words_left = '0;
	logic [1:0] word_pos = '0;
	spvf_pkg::act_t instr_act = spvf_pkg::ACT_PASS;
	logic [spvf_pkg::WORD_W-1:0] held_decor [2];
	bit module_failed = 1'b0;

	out_beat_t filtered_q [$];
	beat_t module_beats [$];
	beat_t dir_rows [DIR_ROWS];

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	logic hold_trig = 1'b0;
	logic hold_seen = 1'b0;
	int unsigned hold_left = 0;

	int unsigned mismatches = 0;
	int unsigned words_in = 0;
	int unsigned results_out = 0;
	int unsigned modules_in = 0;
	int unsigned kind_seen [8];
	int unsigned cycle_cnt = 0;

	spirv_word_stream_filter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_word       (in_word),
		.end_of_stream (end_of_stream),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.out_word      (out_word),
		.kind          (kind),
		.run_last      (run_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void owe_beat(input logic [spvf_pkg::WORD_W-1:0] w,
		input spvf_pkg::kind_t k);
		filtered_q.push_back('{w, k, 1'b0});
	endfunction

	function automatic void module_fault(input spvf_pkg::kind_t k);
		owe_beat('0, k);
		module_failed = 1'b1;
	endfunction

	// Advances the tracked filter state by one accepted word and queues the output beats
	// that word causes. The last of them carries run_last.
	function automatic void filter_word(input logic [spvf_pkg::WORD_W-1:0] w, input logic eos);
		int unsigned first;
		logic [15:0] cnt;
		logic [15:0] opc;
		logic [1:0] pos;
		first = filtered_q.size();
		if (!module_failed) begin
			if (hdr_idx < spvf_pkg::HEADER_WORDS) begin
				if (hdr_idx == 0 && w != spvf_pkg::SPV_MAGIC) begin
					module_fault(spvf_pkg::KIND_MAGIC);
				end else if (hdr_idx == 1 && (w < ver_lo || w > ver_hi)) begin
					module_fault(spvf_pkg::KIND_VERSION);
				end else if (hdr_idx >= spvf_pkg::HEADER_WORDS - 1) begin
					if (w != '0) begin
						module_fault(spvf_pkg::KIND_RESERVED);
					end else begin
						// The header leaves in one burst once the reserved word is clean.
						for (int i = 0; i < spvf_pkg::HDR_STORE_N; i++)
							owe_beat(hdr_words[i], spvf_pkg::KIND_DATA);
						owe_beat(w, spvf_pkg::KIND_DATA);
						hdr_idx = spvf_pkg::HEADER_WORDS;
					end
				end else begin
					hdr_words[hdr_idx[spvf_pkg::HDR_STORE_IDX_W-1:0]] = w;
					hdr_idx = hdr_idx + 1'b1;
				end
			end else if (words_left == '0) begin
				// First word of an instruction: count in the upper half, opcode below.
				cnt = w[31:16];
				opc = w[15:0];
				if (cnt == '0) begin
					module_fault(spvf_pkg::KIND_ZERO);
				end else begin
					words_left = cnt - 16'd1;
					word_pos = 2'd1;
					if (opc == spvf_pkg::OPC_NAME) begin
						instr_act = spvf_pkg::ACT_DROP;
					end else if (opc == spvf_pkg::OPC_DECORATE && cnt >= 16'd3) begin
						instr_act = spvf_pkg::ACT_HOLD;
						held_decor[0] = w;
					end else begin
						instr_act = spvf_pkg::ACT_PASS;
						owe_beat(w, spvf_pkg::KIND_DATA);
					end
				end
			end else begin
				pos = word_pos;
				words_left = words_left - 16'd1;
				case (instr_act)
					spvf_pkg::ACT_PASS: begin
						owe_beat(w, spvf_pkg::KIND_DATA);
					end
					spvf_pkg::ACT_HOLD: begin
						// The third word decides whether the held decoration is released.
						if (pos <= 2'd1) begin
							held_decor[1] = w;
						end else if (w == spvf_pkg::DEC_LINKAGE) begin
							instr_act = spvf_pkg::ACT_DROP;
						end else begin
							owe_beat(held_decor[0], spvf_pkg::KIND_DATA);
							owe_beat(held_decor[1], spvf_pkg::KIND_DATA);
							owe_beat(w, spvf_pkg::KIND_DATA);
							instr_act = spvf_pkg::ACT_PASS;
						end
					end
					default: begin
					end
				endcase
				word_pos = (pos < 2'd3) ? pos + 2'd1 : 2'd3;
			end
			if (eos && !module_failed)
				owe_beat('0, (hdr_idx < spvf_pkg::HEADER_WORDS || words_left != '0) ?
					spvf_pkg::KIND_TRUNC : spvf_pkg::KIND_DONE);
		end
		if (eos) begin
			hdr_idx = '0;
			words_left = '0;
			word_pos = '0;
			instr_act = spvf_pkg::ACT_PASS;
			module_failed = 1'b0;
		end
		if (filtered_q.size() > first)
			filtered_q[filtered_q.size() - 1].last = 1'b1;
	endfunction

	function automatic void note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0d] mismatch: %s", cycle_cnt, msg);
	endfunction

	// Output beats are checked first; a word accepted at this edge cannot have a result yet.
	always @(posedge clk) begin : score
		out_beat_t head;
		int unsigned n_before;
		if (arst_n && out_valid && !out_stall) begin
			results_out++;
			kind_seen[kind]++;
			if (filtered_q.size() == 0) begin
				note_mismatch($sformatf("beat with nothing due: word %h kind %0d last %0b",
					out_word, kind, run_last));
			end else begin
				head = filtered_q.pop_front();
				if (out_word !== head.word || kind !== head.kind || run_last !== head.last)
					note_mismatch($sformatf("expected word %h kind %0d last %0b, got %h %0d %0b",
						head.word, head.kind, head.last, out_word, kind, run_last));
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			n_before = filtered_q.size();
			filter_word(in_word, end_of_stream);
			if (beat_fixed) begin
				// Typed-in rows own their result; the model still advances its state.
				while (filtered_q.size() > n_before)
					filtered_q.delete(filtered_q.size() - 1);
				filtered_q.push_back('{'0, beat_fixed_kind, 1'b1});
			end
			words_in++;
			if (end_of_stream)
				modules_in++;
		end
	end

	// Receiver: random stall, or a long hold-off once the main flow toggles hold_trig.
	always @(posedge clk) begin
		if (hold_trig != hold_seen) begin
			hold_seen <= hold_trig;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles with %0d beats still due", cycle_cnt, filtered_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Offers one beat, after an optional random gap, and returns at the edge that takes it.
	task automatic send_beat(input beat_t b);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= b.word;
		end_of_stream <= b.eos;
		beat_fixed <= b.fixed;
		beat_fixed_kind <= b.fixed_kind;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Waits for every owed beat, then lets any word without results clear the pipeline.
	task automatic settle();
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_versions(input logic [spvf_pkg::WORD_W-1:0] lo,
		input logic [spvf_pkg::WORD_W-1:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= spvf_pkg::CFG_MIN_VERSION;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= spvf_pkg::CFG_MAX_VERSION;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		ver_lo = lo;
		ver_hi = hi;
	endtask

	function automatic void add_word(input logic [spvf_pkg::WORD_W-1:0] w);
		module_beats.push_back('{w, 1'b0, 1'b0, spvf_pkg::KIND_DATA});
	endfunction

	// Builds one random module into module_beats. Most are well formed; the rest carry a
	// header fault, a zero word count or an early end. Returns the number of words that
	// the filter actually looks at (junk after a fault is not counted).
	function automatic int unsigned build_module();
		int unsigned roll;
		int unsigned pick;
		int unsigned fault_at;
		int unsigned cut;
		int unsigned starts [$];
		logic [spvf_pkg::WORD_W-1:0] v;
		logic [15:0] cnt;
		logic [15:0] opc;
		bit faulted;
		module_beats.delete();
		if (ver_lo > ver_hi || (ver_lo == '0 && ver_hi == '1))
			v = $urandom;
		else
			v = $urandom_range(ver_hi, ver_lo);
		add_word(spvf_pkg::SPV_MAGIC);
		add_word(v);
		add_word($urandom);
		add_word($urandom);
		add_word('0);
		for (int n = $urandom_range(6, 1); n > 0; n--) begin
			starts.push_back(module_beats.size());
			pick = $urandom_range(99);
			opc = (pick < 25) ? spvf_pkg::OPC_NAME :
				(pick < 55) ? spvf_pkg::OPC_DECORATE : 16'($urandom);
			if (pick >= 55 && pick < 62) begin
				// Oversized word count: the module ends long before the instruction would.
				add_word({16'hFFFF - 16'($urandom_range(255)), opc});
				repeat ($urandom_range(3)) add_word($urandom);
				break;
			end
			cnt = 16'($urandom_range((opc == spvf_pkg::OPC_DECORATE) ? 5 : 4, 1));
			add_word({cnt, opc});
			for (int k = 1; k < cnt; k++)
				add_word((opc == spvf_pkg::OPC_DECORATE && k == 2 && $urandom_range(1) == 0) ?
					spvf_pkg::DEC_LINKAGE : $urandom);
		end
		roll = $urandom_range(99);
		faulted = 1'b1;
		fault_at = 0;
		if (roll < 6) begin
			module_beats[0].word = roll[0] ? $urandom :
				spvf_pkg::SPV_MAGIC ^ (32'h1 << $urandom_range(31));
		end else if (roll < 12 && !(ver_lo == '0 && ver_hi == '1)) begin
			module_beats[1].word = ((ver_lo != '0 && roll[0]) || ver_hi == '1) ?
				ver_lo - 32'd1 : ver_hi + 32'd1;
			fault_at = 1;
		end else if (roll < 18) begin
			module_beats[4].word = $urandom | (32'h1 << $urandom_range(31));
			fault_at = 4;
		end else if (roll < 24) begin
			fault_at = starts[$urandom_range(starts.size() - 1)];
			module_beats[fault_at].word = {16'h0000, 16'($urandom)};
		end else if (roll < 34) begin
			fault_at = $urandom_range(module_beats.size() - 1);
			faulted = 1'b0;
		end else begin
			fault_at = module_beats.size() - 1;
			faulted = 1'b0;
		end
		cut = faulted ? fault_at + $urandom_range(2) : fault_at;
		if (cut >= module_beats.size())
			cut = module_beats.size() - 1;
		while (module_beats.size() > cut + 1)
			module_beats.delete(module_beats.size() - 1);
		module_beats[cut].eos = 1'b1;
		return fault_at + 1;
	endfunction

	initial begin
		int unsigned phase_words;
		// Directed modules at the reset bounds (1.0 to 1.2). Rows with a typed kind fault
		// or end the module; the others are predicted.
		dir_rows = '{
			'{spvf_pkg::SPV_MAGIC, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0001_0000, 1'b0, 1'b0, spvf_pkg::KIND_DATA},     // lowest version allowed
			'{32'hFFFF_FFFF, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0000_0000, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0000_0000, 1'b0, 1'b0, spvf_pkg::KIND_DATA},     // header leaves in one burst
			'{32'h0001_0005, 1'b0, 1'b0, spvf_pkg::KIND_DATA},     // one-word OpName, dropped
			'{32'h0003_0047, 1'b0, 1'b0, spvf_pkg::KIND_DATA},     // OpDecorate with linkage
			'{32'h8000_0000, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{spvf_pkg::DEC_LINKAGE, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0003_0047, 1'b0, 1'b0, spvf_pkg::KIND_DATA},     // OpDecorate, other decoration
			'{32'h0000_0001, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0000_000B, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0002_0047, 1'b0, 1'b0, spvf_pkg::KIND_DATA},     // too short to be judged
			'{32'h5555_5555, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0001_FFFF, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0000_FFFF, 1'b1, 1'b1, spvf_pkg::KIND_ZERO},
			'{32'h0000_0000, 1'b1, 1'b1, spvf_pkg::KIND_MAGIC},
			'{spvf_pkg::SPV_MAGIC, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0001_0201, 1'b1, 1'b1, spvf_pkg::KIND_VERSION},  // one above the top bound
			'{spvf_pkg::SPV_MAGIC, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h0001_0200, 1'b0, 1'b0, spvf_pkg::KIND_DATA},     // top bound itself
			'{32'h7FFF_FFFF, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'hAAAA_AAAA, 1'b0, 1'b0, spvf_pkg::KIND_DATA},
			'{32'h8000_0000, 1'b1, 1'b1, spvf_pkg::KIND_RESERVED},
			'{spvf_pkg::SPV_MAGIC, 1'b1, 1'b1, spvf_pkg::KIND_TRUNC},  // ends inside the header
			'{32'h0000_0000, 1'b1, 1'b1, spvf_pkg::KIND_MAGIC}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i]);
		in_valid <= 1'b0;
		settle();

		// Random modules, one version window and idle mix per phase. The pressure phase
		// starts with a long receiver hold-off while the sender keeps offering words.
		for (int p = 0; p < N_PHASES; p++) begin
			set_versions(WIN_LO[p], WIN_HI[p]);
			idle_pct = IDLE_PCT[p];
			stall_pct = STALL_PCT[p];
			if (p == PRESSURE_PHASE)
				hold_trig <= ~hold_trig;
			phase_words = 0;
			while (phase_words < PHASE_WORDS[p]) begin
				phase_words += build_module();
				foreach (module_beats[i])
					send_beat(module_beats[i]);
			end
			in_valid <= 1'b0;
			idle_pct = 0;
			stall_pct = 0;
			settle();
		end

		$display("Ran %0d modules (%0d words in, %0d beats out) over five idle mixes and version windows.",
			modules_in, words_in, results_out);
		$display("Kinds out: data %0d done %0d magic %0d version %0d reserved %0d zero %0d trunc %0d",
			kind_seen[spvf_pkg::KIND_DATA], kind_seen[spvf_pkg::KIND_DONE],
			kind_seen[spvf_pkg::KIND_MAGIC], kind_seen[spvf_pkg::KIND_VERSION],
			kind_seen[spvf_pkg::KIND_RESERVED], kind_seen[spvf_pkg::KIND_ZERO],
			kind_seen[spvf_pkg::KIND_TRUNC]);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
